// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent assertions on a clock with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/dscr_pkg.sv =====
// ----------------------------------------------------------------------------
// dscr_pkg
// shared constants and types of the depthwise separable conv1d relu block
// ----------------------------------------------------------------------------
package dscr_pkg;

	// default geometry
	localparam int IN_CHANNELS_DEF = 4;
	localparam int SAMPLES_DEF     = 400;
	localparam int OUT_CHANNELS_DEF = 16;
	localparam int TAPS_DEF        = 4;
	localparam int STRIDE_DEF      = 2;

	// arithmetic
	localparam int ACC_W    = 24;
	localparam int RES_W    = 16;
	localparam int PW_SHIFT = 7;

	// field widths
	localparam int COEF_IDX_W = 7;
	localparam int DATA_W     = 8;
	localparam int RELU_W     = 15;
	localparam int OCH_W      = 4;
	localparam int POS_W      = 8;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 24;

	// input item kinds
	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DW,
		ST_GAP,
		ST_PW
	} state_t;

	// kind of work carried down the mac pipeline
	typedef enum logic [1:0] {
		KIND_DW,
		KIND_PW,
		KIND_BIAS
	} kind_t;

endpackage

// ===== src/depthwise_separable_conv1d_relu.sv =====
// A coefficient load or a sample that completes no window leaves s_tready high. A
// sample that completes a window drops s_tready while the sequencer runs the
// depthwise taps of every input channel, a gap state, then the pointwise products
// and bias of each output channel in turn; one shared mac on the single coefficient
// memory read port works through them, and a stalled result holds the pipeline.
// Reset clears control state only; the sample and coefficient memories keep contents.
// ----------------------------------------------------------------------------
// depthwise_separable_conv1d_relu
// int8 depthwise 1-d convolution, pointwise mix, shift, bias and relu, built
// around a sample memory and a coefficient memory feeding one mac pipeline
// ----------------------------------------------------------------------------
module depthwise_separable_conv1d_relu #(
	parameter int IN_CHANNELS         = dscr_pkg::IN_CHANNELS_DEF,
	parameter int SAMPLES_PER_CHANNEL = dscr_pkg::SAMPLES_DEF,
	parameter int OUT_CHANNELS        = dscr_pkg::OUT_CHANNELS_DEF,
	parameter int TAPS                = dscr_pkg::TAPS_DEF,
	parameter int STRIDE              = dscr_pkg::STRIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// coef_index [6:0], data_value [14:7], zero [15]
	input  logic [dscr_pkg::S_TDATA_W-1:0] s_tdata,
	// operation [0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// relu_value [14:0], position [22:15], zero [23]
	output logic [dscr_pkg::M_TDATA_W-1:0] m_tdata,
	// out_channel [3:0]
	output logic [dscr_pkg::OCH_W-1:0]     m_tuser,
	// last_in_run
	output logic                           m_tlast
);

	localparam int FRAME_LEN  = IN_CHANNELS * SAMPLES_PER_CHANNEL;
	localparam int PW_BASE    = IN_CHANNELS * TAPS;
	localparam int BIAS_BASE  = PW_BASE + OUT_CHANNELS * IN_CHANNELS;
	localparam int COEF_COUNT = BIAS_BASE + OUT_CHANNELS;
	localparam int POSITIONS  = (SAMPLES_PER_CHANNEL - TAPS) / STRIDE + 1;
	localparam int CH_STEP    = SAMPLES_PER_CHANNEL - TAPS + 1;

	localparam int A_W  = $clog2(FRAME_LEN);
	localparam int CA_W = $clog2(COEF_COUNT);
	localparam int T_W  = $clog2(SAMPLES_PER_CHANNEL);
	localparam int NT_W = $clog2(SAMPLES_PER_CHANNEL + STRIDE);
	localparam int PC_W = $clog2(POSITIONS + 1);
	localparam int C_W  = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
	localparam int J_W  = $clog2(IN_CHANNELS + 1);
	localparam int K_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int O_W  = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
	localparam int DW_W = dscr_pkg::DATA_W;
	localparam int AC_W = dscr_pkg::ACC_W;

	typedef struct packed {
		dscr_pkg::kind_t kind;
		logic            first;
		logic            last;
		logic [C_W-1:0]  ch;
		logic [O_W-1:0]  oc;
	} tag_t;

	// input fields
	logic                           op;
	logic [dscr_pkg::COEF_IDX_W-1:0] coef_index;
	logic signed [DW_W-1:0]         data_value;

	assign op         = s_tuser;
	assign coef_index = s_tdata[dscr_pkg::COEF_IDX_W-1:0];
	assign data_value = s_tdata[dscr_pkg::COEF_IDX_W +: DW_W];

	// memories
	logic signed [DW_W-1:0] smp_mem  [FRAME_LEN];
	logic signed [DW_W-1:0] coef_mem [COEF_COUNT];

	// frame tracking
	logic [A_W-1:0]  wr_q;
	logic [T_W-1:0]  t_q;
	logic [C_W-1:0]  fch_q;
	logic [NT_W-1:0] nt_q;
	logic [PC_W-1:0] p_q;

	// sequencer
	dscr_pkg::state_t state_q, state_d;
	logic [K_W-1:0]  k_q;
	logic [C_W-1:0]  c_q;
	logic [J_W-1:0]  j_q;
	logic [O_W-1:0]  o_q;
	logic [A_W-1:0]  smp_addr_q;
	logic [CA_W-1:0] coef_addr_q;
	logic [CA_W-1:0] bias_addr_q;
	logic [PC_W-1:0] p_run_q;

	// pipeline
	logic                   v_s1, v_s2;
	tag_t                   tag_s1, tag_s2, tag_issue;
	logic signed [DW_W-1:0] smp_rd_s1, coef_rd_s1;
	logic signed [AC_W-1:0] prod_s2;
	logic signed [AC_W-1:0] acc_q;
	logic signed [AC_W-1:0] dw_q [IN_CHANNELS];

	// output register
	logic                            out_vld_q;
	logic [dscr_pkg::RELU_W-1:0]     out_relu_q;
	logic [dscr_pkg::OCH_W-1:0]      out_ch_q;
	logic [dscr_pkg::POS_W-1:0]      out_pos_q;
	logic                            out_last_q;

	logic            accept, is_sample, hit, window, en, issue, bias_slot;
	logic [CA_W-1:0] coef_raddr;

	// handshake and window detection
	assign s_tready  = (state_q == dscr_pkg::ST_IDLE) && !v_s1 && !v_s2;
	assign accept    = s_tvalid && s_tready;
	assign is_sample = (op == dscr_pkg::OP_SAMPLE);
	assign hit       = (NT_W'(t_q) == nt_q);
	assign window    = accept && is_sample && hit && (fch_q == C_W'(IN_CHANNELS - 1));

	// pipeline stalls only when a finished result cannot enter the output register
	assign en = !(v_s2 && (tag_s2.kind == dscr_pkg::KIND_BIAS) && out_vld_q && !m_tready);

	assign issue     = (state_q == dscr_pkg::ST_DW) || (state_q == dscr_pkg::ST_PW);
	assign bias_slot = (state_q == dscr_pkg::ST_PW) && (j_q == J_W'(IN_CHANNELS));
	assign coef_raddr = bias_slot ? bias_addr_q : coef_addr_q;

	// tag of the item issued this cycle
	always_comb begin
		tag_issue = '0;
		if (state_q == dscr_pkg::ST_DW) begin
			tag_issue.kind  = dscr_pkg::KIND_DW;
			tag_issue.first = (k_q == '0);
			tag_issue.last  = (k_q == K_W'(TAPS - 1));
			tag_issue.ch    = c_q;
		end else begin
			tag_issue.kind  = bias_slot ? dscr_pkg::KIND_BIAS : dscr_pkg::KIND_PW;
			tag_issue.first = (j_q == '0);
			tag_issue.ch    = j_q[C_W-1:0];
			tag_issue.oc    = o_q;
		end
	end

	// sample memory: write on transfer, read per mac step
	always_ff @(posedge clk) begin
		if (accept && is_sample)
			smp_mem[wr_q] <= data_value;
		if (en)
			smp_rd_s1 <= smp_mem[smp_addr_q];
	end

	// coefficient memory: loads beyond the store are dropped
	always_ff @(posedge clk) begin
		if (accept && !is_sample && (int'(coef_index) < COEF_COUNT))
			coef_mem[CA_W'(coef_index)] <= data_value;
		if (en)
			coef_rd_s1 <= coef_mem[coef_raddr];
	end

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			t_q   <= '0;
			fch_q <= '0;
			nt_q  <= NT_W'(TAPS - 1);
			p_q   <= '0;
		end else if (accept && is_sample) begin
			wr_q <= (wr_q == A_W'(FRAME_LEN - 1)) ? '0 : wr_q + A_W'(1);
			if (t_q == T_W'(SAMPLES_PER_CHANNEL - 1)) begin
				t_q   <= '0;
				nt_q  <= NT_W'(TAPS - 1);
				p_q   <= '0;
				fch_q <= (fch_q == C_W'(IN_CHANNELS - 1)) ? '0 : fch_q + C_W'(1);
			end else begin
				t_q <= t_q + T_W'(1);
				if (hit) begin
					nt_q <= nt_q + NT_W'(STRIDE);
					p_q  <= p_q + PC_W'(1);
				end
			end
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dscr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dscr_pkg::ST_IDLE: begin
				if (window)
					state_d = dscr_pkg::ST_DW;
			end
			dscr_pkg::ST_DW: begin
				if (en && (k_q == K_W'(TAPS - 1)) && (c_q == C_W'(IN_CHANNELS - 1)))
					state_d = dscr_pkg::ST_GAP;
			end
			dscr_pkg::ST_GAP: begin
				state_d = dscr_pkg::ST_PW;
			end
			dscr_pkg::ST_PW: begin
				if (en && bias_slot && (o_q == O_W'(OUT_CHANNELS - 1)))
					state_d = dscr_pkg::ST_IDLE;
			end
			default: state_d = dscr_pkg::ST_IDLE;
		endcase
	end

	// sequencer address and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			c_q         <= '0;
			j_q         <= '0;
			o_q         <= '0;
			smp_addr_q  <= '0;
			coef_addr_q <= '0;
			bias_addr_q <= '0;
			p_run_q     <= '0;
		end else if (window) begin
			k_q         <= '0;
			c_q         <= '0;
			j_q         <= '0;
			o_q         <= '0;
			smp_addr_q  <= A_W'(t_q) - A_W'(TAPS - 1);
			coef_addr_q <= '0;
			bias_addr_q <= CA_W'(BIAS_BASE);
			p_run_q     <= p_q;
		end else if (en) begin
			case (state_q)
				dscr_pkg::ST_DW: begin
					coef_addr_q <= coef_addr_q + CA_W'(1);
					if (k_q == K_W'(TAPS - 1)) begin
						k_q        <= '0;
						c_q        <= c_q + C_W'(1);
						smp_addr_q <= smp_addr_q + A_W'(CH_STEP);
					end else begin
						k_q        <= k_q + K_W'(1);
						smp_addr_q <= smp_addr_q + A_W'(1);
					end
				end
				dscr_pkg::ST_PW: begin
					if (bias_slot) begin
						j_q         <= '0;
						o_q         <= o_q + O_W'(1);
						bias_addr_q <= bias_addr_q + CA_W'(1);
					end else begin
						j_q         <= j_q + J_W'(1);
						coef_addr_q <= coef_addr_q + CA_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// stage 1: multiply sample or depthwise sum by coefficient, or pass the bias
	logic signed [2*DW_W-1:0]      dw_prod;
	logic signed [AC_W+DW_W-1:0]   pw_prod;

	assign dw_prod = smp_rd_s1 * coef_rd_s1;
	assign pw_prod = dw_q[tag_s1.ch] * coef_rd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_issue;
			tag_s2 <= tag_s1;
			case (tag_s1.kind)
				dscr_pkg::KIND_DW: prod_s2 <= AC_W'(dw_prod);
				dscr_pkg::KIND_PW: prod_s2 <= pw_prod[AC_W-1:0];
				default:           prod_s2 <= AC_W'(coef_rd_s1);
			endcase
		end
	end

	// stage 2: accumulate, keep depthwise sums
	logic signed [AC_W-1:0] acc_sum;

	assign acc_sum = (tag_s2.first ? '0 : acc_q) + prod_s2;

	always_ff @(posedge clk) begin
		if (en && v_s2 && (tag_s2.kind != dscr_pkg::KIND_BIAS)) begin
			acc_q <= acc_sum;
			if ((tag_s2.kind == dscr_pkg::KIND_DW) && tag_s2.last)
				dw_q[tag_s2.ch] <= acc_sum;
		end
	end

	// shift, bias add with 16-bit wrap, relu
	logic [dscr_pkg::RES_W-1:0] shifted, biased;
	logic [dscr_pkg::RELU_W-1:0] relu;

	assign shifted = acc_q[dscr_pkg::PW_SHIFT +: dscr_pkg::RES_W];
	assign biased  = shifted + dscr_pkg::RES_W'(prod_s2[DW_W-1:0] == '0 ? 0 : 0)
		+ {{(dscr_pkg::RES_W - DW_W){prod_s2[DW_W-1]}}, prod_s2[DW_W-1:0]};
	assign relu    = biased[dscr_pkg::RES_W-1] ? '0 : biased[dscr_pkg::RELU_W-1:0];

	// output register
	logic load_out;

	assign load_out = en && v_s2 && (tag_s2.kind == dscr_pkg::KIND_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (load_out)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_relu_q <= relu;
			out_ch_q   <= dscr_pkg::OCH_W'(tag_s2.oc);
			out_pos_q  <= dscr_pkg::POS_W'(p_run_q);
			out_last_q <= (tag_s2.oc == O_W'(OUT_CHANNELS - 1));
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_pos_q, out_relu_q};
	assign m_tuser  = out_ch_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== src/dscr_checker.sv =====
// ----------------------------------------------------------------------------
// dscr_checker
// port-level checks on result ordering and flow control, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dscr_checker #(
	parameter int OUT_CHANNELS = dscr_pkg::OUT_CHANNELS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [dscr_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [dscr_pkg::OCH_W-1:0]     m_tuser,
	input logic                           m_tlast
);

	// a stalled result holds still
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

	// the last result of a run belongs to the last output channel
	`ASSERT_CLK(a_last_channel, clk, arst_n, m_tvalid && m_tlast |-> m_tuser == dscr_pkg::OCH_W'(OUT_CHANNELS - 1), "run ended on wrong channel")

	// no input is taken while a run still has results to deliver
	`ASSERT_NEVER(a_busy_mid_run, clk, arst_n, m_tvalid && !m_tlast && s_tready, "input ready in the middle of a run")

	// a new run never follows the last transfer on the next cycle
	`ASSERT_CLK(a_run_gap, clk, arst_n, m_tvalid && m_tready && m_tlast |=> !m_tvalid, "result right after end of run")

endmodule

bind depthwise_separable_conv1d_relu dscr_checker #(
	.OUT_CHANNELS(OUT_CHANNELS)
) u_dscr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
